// ===== hdl/rpdc_pkg.sv =====
// Shared types and constants of the range packet deframer and checker.
package rpdc_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SIZE,
        PH_COUNT,
        PH_PAYLOAD,
        PH_CHK_LO,
        PH_CHK_HI
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_CHECKSUM     = 3'd1,
        ST_BAD_SIZE     = 3'd2,
        ST_HUNT_TIMEOUT = 3'd3,
        ST_LINK_FAULT   = 3'd4
    } status_t;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_PACKET = 1'b1;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;

    localparam logic [7:0] SIZE_CODE_2B = 8'h02;
    localparam logic [7:0] SIZE_CODE_3B = 8'h03;
    localparam logic [7:0] SIZE_CODE_4B = 8'h07;

    localparam logic [31:0] CHK_SEED         = 32'h0000_AA55;
    localparam logic [7:0]  HUNT_LIMIT_RESET = 8'd100;

    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [7:0]  sample_index;
        logic [13:0] distance;
        logic        invalid;
        logic [15:0] quality;
        logic [9:0]  speed_rpm;
        logic [15:0] first_angle_word;
        logic [15:0] last_angle_word;
        logic [7:0]  sample_count;
        logic [2:0]  sample_bytes;
    } result_t;

endpackage

// ===== hdl/range_packet_deframer_checker.sv =====
// Range packet deframer and checker: top level with framing, checksum and result buffer.
//
// The block takes one received byte per input beat and accepts a beat on every clock
// cycle as long as its two-entry result buffer (output register plus skid register) has a
// free slot; s_ready is a register and does not depend on m_ready. A byte is decoded in the
// cycle it is accepted, and any result it causes is presented on the m_ side on the next
// cycle, or waits in the skid register while the output register is stalled. The block
// hunts for the header 0x55 0xAA, then reads a size code (0x02, 0x03 or
// 0x07 for 2, 3 or 4 bytes per sample) and a sample count, then the payload: speed word,
// first angle word, the samples, last angle word, all little endian, and finally a 16-bit
// checksum word. Every completed sample yields a result with kind 0; the last checksum
// byte yields a packet-end result with kind 1 and status ok or checksum mismatch. Bad size
// codes, header hunt timeouts (after header_hunt_limit bytes, written through the cfg_
// port, reset value 100) and beats flagged with link_fault yield a kind 1 result carrying
// only the error status, and the block returns to the hunt. Write cfg_ only while idle.
module range_packet_deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_link_fault,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_status,
    output logic [7:0]  m_sample_index,
    output logic [13:0] m_distance,
    output logic        m_invalid,
    output logic [15:0] m_quality,
    output logic [9:0]  m_speed_rpm,
    output logic [15:0] m_first_angle_word,
    output logic [15:0] m_last_angle_word,
    output logic [7:0]  m_sample_count,
    output logic [2:0]  m_sample_bytes
);

    // Framing state
    rpdc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  limit_reg, limit_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [7:0]  hunt_count_reg, hunt_count_next;

    // Packet datapath
    logic [2:0]  bps_reg, bps_next;
    logic [7:0]  count_reg, count_next;
    logic [10:0] pos_reg, pos_next;
    logic [10:0] data_len_reg, data_len_next;
    logic [1:0]  sub_reg, sub_next;
    logic [7:0]  idx_reg, idx_next;
    logic [23:0] held_reg, held_next;
    logic [7:0]  pend_reg, pend_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] speed_reg, speed_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] last_reg, last_next;
    logic [7:0]  chk_lo_reg, chk_lo_next;

    // Result buffer
    rpdc_pkg::result_t out_reg, out_next;
    rpdc_pkg::result_t skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    rpdc_pkg::result_t res;
    logic        res_fire;

    logic        in_fire;
    logic [7:0]  b;
    logic [2:0]  size_dec;
    logic        bad_size;
    logic        found;
    logic [7:0]  hunt_inc;
    logic        timeout;
    logic        pay_last;
    logic [1:0]  last_sub;
    logic [14:0] fold;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign in_fire   = s_valid && s_ready;
    assign b         = s_rx_byte;

    // Decode the size code held from the previous byte
    always_comb begin
        unique case (pend_reg)
            rpdc_pkg::SIZE_CODE_2B: size_dec = 3'd2;
            rpdc_pkg::SIZE_CODE_3B: size_dec = 3'd3;
            rpdc_pkg::SIZE_CODE_4B: size_dec = 3'd4;
            default:                size_dec = 3'd0;
        endcase
    end

    assign bad_size = (size_dec == 3'd0);
    assign found    = (prev_byte_reg == rpdc_pkg::HDR_FIRST) && (b == rpdc_pkg::HDR_SECOND);
    assign hunt_inc = hunt_count_reg + 8'd1;
    assign timeout  = (hunt_inc >= limit_reg);
    assign pay_last = (pos_reg >= (data_len_reg - 11'd1));
    assign last_sub = 2'(bps_reg - 3'd1);
    assign fold     = 15'({1'b0, acc_reg[14:0]} + {1'b0, acc_reg[29:15]});

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            if (s_link_fault) begin
                phase_next = rpdc_pkg::PH_HUNT;
            end else begin
                unique case (phase_reg)
                    rpdc_pkg::PH_HUNT: begin
                        if (!timeout && found) begin
                            phase_next = rpdc_pkg::PH_SIZE;
                        end
                    end
                    rpdc_pkg::PH_SIZE:    phase_next = rpdc_pkg::PH_COUNT;
                    rpdc_pkg::PH_COUNT: begin
                        phase_next = bad_size ? rpdc_pkg::PH_HUNT : rpdc_pkg::PH_PAYLOAD;
                    end
                    rpdc_pkg::PH_PAYLOAD: begin
                        if (pay_last) begin
                            phase_next = rpdc_pkg::PH_CHK_LO;
                        end
                    end
                    rpdc_pkg::PH_CHK_LO:  phase_next = rpdc_pkg::PH_CHK_HI;
                    rpdc_pkg::PH_CHK_HI:  phase_next = rpdc_pkg::PH_HUNT;
                    default:              phase_next = rpdc_pkg::PH_HUNT;
                endcase
            end
        end
    end

    // Datapath updates and the result of the current beat
    always_comb begin
        limit_next      = cfg_valid ? cfg_data : limit_reg;
        prev_byte_next  = prev_byte_reg;
        hunt_count_next = hunt_count_reg;
        bps_next        = bps_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        data_len_next   = data_len_reg;
        sub_next        = sub_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        pend_next       = pend_reg;
        acc_next        = acc_reg;
        speed_next      = speed_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        chk_lo_next     = chk_lo_reg;
        res             = '0;
        res_fire        = 1'b0;

        if (in_fire) begin
            if (s_link_fault) begin
                res.kind        = rpdc_pkg::KIND_PACKET;
                res.status      = rpdc_pkg::ST_LINK_FAULT;
                res_fire        = 1'b1;
                prev_byte_next  = '0;
                hunt_count_next = '0;
            end else begin
                unique case (phase_reg)
                    rpdc_pkg::PH_HUNT: begin
                        prev_byte_next  = b;
                        hunt_count_next = hunt_inc;
                        if (timeout) begin
                            res.kind        = rpdc_pkg::KIND_PACKET;
                            res.status      = rpdc_pkg::ST_HUNT_TIMEOUT;
                            res_fire        = 1'b1;
                            prev_byte_next  = '0;
                            hunt_count_next = '0;
                        end else if (found) begin
                            acc_next = rpdc_pkg::CHK_SEED;
                        end
                    end
                    rpdc_pkg::PH_SIZE: begin
                        pend_next = b;
                    end
                    rpdc_pkg::PH_COUNT: begin
                        count_next = b;
                        bps_next   = size_dec;
                        if (bad_size) begin
                            res.kind        = rpdc_pkg::KIND_PACKET;
                            res.status      = rpdc_pkg::ST_BAD_SIZE;
                            res_fire        = 1'b1;
                            prev_byte_next  = '0;
                            hunt_count_next = '0;
                        end else begin
                            acc_next      = {acc_reg[30:0], 1'b0} + {16'd0, b, pend_reg};
                            data_len_next = ({3'd0, b} * {8'd0, size_dec}) + 11'd6;
                            pos_next      = '0;
                            sub_next      = '0;
                            idx_next      = '0;
                            held_next     = '0;
                            speed_next    = '0;
                            first_next    = '0;
                            last_next     = '0;
                        end
                    end
                    rpdc_pkg::PH_PAYLOAD: begin
                        // Pair bytes into checksum words
                        if (!pos_reg[0]) begin
                            pend_next = b;
                        end else begin
                            acc_next = {acc_reg[30:0], 1'b0} + {16'd0, b, pend_reg};
                        end

                        if (pos_reg < 11'd2) begin
                            if (pos_reg[0]) speed_next[15:8] = b;
                            else            speed_next = {8'd0, b};
                        end else if (pos_reg < 11'd4) begin
                            if (pos_reg[0]) first_next[15:8] = b;
                            else            first_next = {8'd0, b};
                        end else if (pos_reg < (data_len_reg - 11'd2)) begin
                            case (sub_reg)
                                2'd0:    held_next[7:0]   = b;
                                2'd1:    held_next[15:8]  = b;
                                2'd2:    held_next[23:16] = b;
                                default: held_next        = held_reg;
                            endcase
                            if (sub_reg == last_sub) begin
                                res.kind             = rpdc_pkg::KIND_SAMPLE;
                                res.status           = rpdc_pkg::ST_OK;
                                res.sample_index     = idx_reg;
                                res.distance         = {held_next[13:8], held_next[7:0]};
                                res.invalid          = ({held_next[13:8], held_next[7:0]} == '0)
                                                       || held_next[15];
                                case (bps_reg)
                                    3'd3:    res.quality = {8'd0, held_next[23:16]};
                                    3'd4:    res.quality = {b, held_next[23:16]};
                                    default: res.quality = '0;
                                endcase
                                res.speed_rpm        = speed_reg[15:6];
                                res.first_angle_word = first_reg;
                                res.sample_count     = count_reg;
                                res.sample_bytes     = bps_reg;
                                res_fire             = 1'b1;
                                sub_next             = '0;
                                idx_next             = idx_reg + 8'd1;
                            end else begin
                                sub_next = sub_reg + 2'd1;
                            end
                        end else begin
                            if (pos_reg == (data_len_reg - 11'd2)) last_next = {8'd0, b};
                            else                                   last_next[15:8] = b;
                        end

                        if (!pay_last) begin
                            pos_next = pos_reg + 11'd1;
                        end
                    end
                    rpdc_pkg::PH_CHK_LO: begin
                        chk_lo_next = b;
                    end
                    rpdc_pkg::PH_CHK_HI: begin
                        res.kind             = rpdc_pkg::KIND_PACKET;
                        res.status           = ({1'b0, fold} == {b, chk_lo_reg})
                                               ? rpdc_pkg::ST_OK : rpdc_pkg::ST_CHECKSUM;
                        res.speed_rpm        = speed_reg[15:6];
                        res.first_angle_word = first_reg;
                        res.last_angle_word  = last_reg;
                        res.sample_count     = count_reg;
                        res.sample_bytes     = bps_reg;
                        res_fire             = 1'b1;
                        prev_byte_next       = '0;
                        hunt_count_next      = '0;
                    end
                    default: begin
                        prev_byte_next  = '0;
                        hunt_count_next = '0;
                    end
                endcase
            end
        end
    end

    // Result buffer: advance skid into the output register when it drains;
    // a new result lands in the skid only while the output register stalls.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = res_fire;
            end
        end else if (res_fire) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= rpdc_pkg::PH_HUNT;
            limit_reg      <= rpdc_pkg::HUNT_LIMIT_RESET;
            prev_byte_reg  <= '0;
            hunt_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            limit_reg      <= limit_next;
            prev_byte_reg  <= prev_byte_next;
            hunt_count_reg <= hunt_count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        bps_reg      <= bps_next;
        count_reg    <= count_next;
        pos_reg      <= pos_next;
        data_len_reg <= data_len_next;
        sub_reg      <= sub_next;
        idx_reg      <= idx_next;
        held_reg     <= held_next;
        pend_reg     <= pend_next;
        acc_reg      <= acc_next;
        speed_reg    <= speed_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        chk_lo_reg   <= chk_lo_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_kind             = out_reg.kind;
    assign m_status           = out_reg.status;
    assign m_sample_index     = out_reg.sample_index;
    assign m_distance         = out_reg.distance;
    assign m_invalid          = out_reg.invalid;
    assign m_quality          = out_reg.quality;
    assign m_speed_rpm        = out_reg.speed_rpm;
    assign m_first_angle_word = out_reg.first_angle_word;
    assign m_last_angle_word  = out_reg.last_angle_word;
    assign m_sample_count     = out_reg.sample_count;
    assign m_sample_bytes     = out_reg.sample_bytes;

endmodule

// ===== hdl/rpdc_checker.sv =====
// Port-level assertions for the range packet deframer and checker, with bind.
module rpdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [2:0]  m_status,
    input logic [7:0]  m_sample_index,
    input logic [13:0] m_distance,
    input logic        m_invalid,
    input logic [15:0] m_quality,
    input logic [9:0]  m_speed_rpm,
    input logic [15:0] m_first_angle_word,
    input logic [15:0] m_last_angle_word,
    input logic [7:0]  m_sample_count,
    input logic [2:0]  m_sample_bytes
);

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_distance)
                                && $stable(m_sample_index))
        else $error("result beat changed while stalled");

    // Error beats carry nothing but the status
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind && (m_status == rpdc_pkg::ST_BAD_SIZE
            || m_status == rpdc_pkg::ST_HUNT_TIMEOUT || m_status == rpdc_pkg::ST_LINK_FAULT)
        |-> m_sample_count == '0 && m_sample_bytes == '0 && m_speed_rpm == '0
            && m_first_angle_word == '0 && m_last_angle_word == '0)
        else $error("error beat carries packet fields");

    // Sample beats come only from a good size code
    a_sample_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_status == rpdc_pkg::ST_OK && m_last_angle_word == '0
            && (m_sample_bytes == 3'd2 || m_sample_bytes == 3'd3 || m_sample_bytes == 3'd4))
        else $error("malformed sample beat");

    // Zero distance is always flagged invalid; two-byte samples have no quality
    a_sample_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> (m_distance != '0 || m_invalid)
            && (m_sample_bytes != 3'd2 || m_quality == '0))
        else $error("sample distance or quality inconsistent");

endmodule

bind range_packet_deframer_checker rpdc_checker u_rpdc_checker (.*);

// ===== tb/sv/deframe_check.sv =====
// Deframer result predictor and comparator, instantiated beside the block in the testbench.
module deframe_check (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_link_fault,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [2:0]  m_status,
    input  logic [7:0]  m_sample_index,
    input  logic [13:0] m_distance,
    input  logic        m_invalid,
    input  logic [15:0] m_quality,
    input  logic [9:0]  m_speed_rpm,
    input  logic [15:0] m_first_angle_word,
    input  logic [15:0] m_last_angle_word,
    input  logic [7:0]  m_sample_count,
    input  logic [2:0]  m_sample_bytes,

    output int          mismatch_count,
    output int          results_due
);

    localparam int DUE_DEPTH = 256;

    rpdc_pkg::phase_t  phase;
    logic [7:0]        hunt_limit;
    logic [7:0]        prev_byte;
    logic [7:0]        hunt_count;
    logic [7:0]        count_held;
    logic [7:0]        pend_low;
    logic [7:0]        chk_low;
    logic [2:0]        bps;
    logic [10:0]       pos;
    logic [23:0]       held;
    logic [31:0]       acc;
    logic [15:0]       speed_word;
    logic [15:0]       first_angle;
    logic [15:0]       last_angle;
    rpdc_pkg::result_t due_buf[DUE_DEPTH];
    logic [7:0]        due_wr;
    logic [7:0]        due_rd;
    int                due_level = 0;
    rpdc_pkg::result_t want;
    int                bad = 0;

    // Ring of predicted results still waiting for their beat.
    task automatic queue_result(input rpdc_pkg::result_t r);
        due_buf[due_wr] = r;
        due_wr          = due_wr + 8'd1;
        due_level++;
    endtask

    task automatic restart_hunt();
        phase      = rpdc_pkg::PH_HUNT;
        prev_byte  = '0;
        hunt_count = '0;
    endtask

    task automatic push_error(input rpdc_pkg::status_t code);
        rpdc_pkg::result_t r;
        r        = '0;
        r.kind   = rpdc_pkg::KIND_PACKET;
        r.status = code;
        queue_result(r);
        restart_hunt();
    endtask

    task automatic add_word(input logic [15:0] w);
        acc = (acc << 1) + {16'h0000, w};
    endtask

    // Advance the predicted deframer by one received byte, queue any result.
    task automatic deframe_byte(input logic [7:0] b, input logic fault);
        rpdc_pkg::result_t r;
        int          p;
        int          dlen;
        int          rel;
        int          q;
        logic        hit;
        logic [14:0] fold;
        logic [13:0] raw_dist;
        r    = '0;
        p    = pos;
        dlen = int'(count_held) * int'(bps) + 6;
        if (fault) begin
            push_error(rpdc_pkg::ST_LINK_FAULT);
        end else begin
            case (phase)
                rpdc_pkg::PH_SIZE: begin
                    pend_low = b;
                    phase    = rpdc_pkg::PH_COUNT;
                end
                rpdc_pkg::PH_COUNT: begin
                    count_held = b;
                    case (pend_low)
                        rpdc_pkg::SIZE_CODE_2B: bps = 3'd2;
                        rpdc_pkg::SIZE_CODE_3B: bps = 3'd3;
                        rpdc_pkg::SIZE_CODE_4B: bps = 3'd4;
                        default:                bps = 3'd0;
                    endcase
                    if (bps == 3'd0) begin
                        push_error(rpdc_pkg::ST_BAD_SIZE);
                    end else begin
                        add_word({b, pend_low});
                        pos         = '0;
                        speed_word  = '0;
                        first_angle = '0;
                        last_angle  = '0;
                        held        = '0;
                        phase       = rpdc_pkg::PH_PAYLOAD;
                    end
                end
                rpdc_pkg::PH_PAYLOAD: begin
                    if (pos[0] == 1'b0) pend_low = b;
                    else add_word({b, pend_low});
                    if (p < 2) begin
                        if (p == 0) speed_word = {8'h00, b};
                        else speed_word[15:8] = b;
                    end else if (p < 4) begin
                        if (p == 2) first_angle = {8'h00, b};
                        else first_angle[15:8] = b;
                    end else if (p < dlen - 2) begin
                        rel = p - 4;
                        q   = rel % int'(bps);
                        if (q < 3) held[8*q +: 8] = b;
                        if (q == int'(bps) - 1) begin
                            raw_dist           = {held[13:8], held[7:0]};
                            r.kind             = rpdc_pkg::KIND_SAMPLE;
                            r.status           = rpdc_pkg::ST_OK;
                            r.sample_index     = 8'(rel / int'(bps));
                            r.distance         = raw_dist;
                            r.invalid          = (raw_dist == '0) ? 1'b1 : held[15];
                            r.quality          = (bps == 3'd3) ? {8'h00, held[23:16]} :
                                                 (bps == 3'd4) ? {b, held[23:16]} : 16'h0000;
                            r.speed_rpm        = speed_word[15:6];
                            r.first_angle_word = first_angle;
                            r.sample_count     = count_held;
                            r.sample_bytes     = bps;
                            queue_result(r);
                        end
                    end else begin
                        if (p == dlen - 2) last_angle = {8'h00, b};
                        else last_angle[15:8] = b;
                    end
                    if (p + 1 >= dlen) phase = rpdc_pkg::PH_CHK_LO;
                    else pos = pos + 11'd1;
                end
                rpdc_pkg::PH_CHK_LO: begin
                    chk_low = b;
                    phase   = rpdc_pkg::PH_CHK_HI;
                end
                rpdc_pkg::PH_CHK_HI: begin
                    fold               = acc[14:0] + acc[29:15];
                    r.kind             = rpdc_pkg::KIND_PACKET;
                    r.status           = ({b, chk_low} == {1'b0, fold}) ? rpdc_pkg::ST_OK
                                                                        : rpdc_pkg::ST_CHECKSUM;
                    r.speed_rpm        = speed_word[15:6];
                    r.first_angle_word = first_angle;
                    r.last_angle_word  = last_angle;
                    r.sample_count     = count_held;
                    r.sample_bytes     = bps;
                    queue_result(r);
                    restart_hunt();
                end
                default: begin
                    hit        = (prev_byte == rpdc_pkg::HDR_FIRST) &&
                                 (b == rpdc_pkg::HDR_SECOND);
                    prev_byte  = b;
                    hunt_count = hunt_count + 8'd1;
                    if (hunt_count >= hunt_limit) begin
                        push_error(rpdc_pkg::ST_HUNT_TIMEOUT);
                    end else if (hit) begin
                        acc   = rpdc_pkg::CHK_SEED;
                        phase = rpdc_pkg::PH_SIZE;
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            bad++;
            if (bad <= 10)
                $display("mismatch %0d: %s expected 0x%0h got 0x%0h", bad, name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_hunt();
            hunt_limit  = rpdc_pkg::HUNT_LIMIT_RESET;
            bps         = '0;
            count_held  = '0;
            pos         = '0;
            held        = '0;
            pend_low    = '0;
            acc         = '0;
            speed_word  = '0;
            first_angle = '0;
            last_angle  = '0;
            chk_low     = '0;
            due_wr      = '0;
            due_rd      = '0;
            due_level   = 0;
        end else begin
            if (cfg_valid && cfg_ready) hunt_limit = cfg_data;
            if (s_valid && s_ready) deframe_byte(s_rx_byte, s_link_fault);
            if (m_valid && m_ready) begin
                if (due_level == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("mismatch %0d: unexpected result beat, kind %0d status %0d",
                                 bad, m_kind, m_status);
                end else begin
                    want   = due_buf[due_rd];
                    due_rd = due_rd + 8'd1;
                    due_level--;
                    check_field("kind", want.kind, m_kind);
                    check_field("status", want.status, m_status);
                    check_field("sample_index", want.sample_index, m_sample_index);
                    check_field("distance", want.distance, m_distance);
                    check_field("invalid", want.invalid, m_invalid);
                    check_field("quality", want.quality, m_quality);
                    check_field("speed_rpm", want.speed_rpm, m_speed_rpm);
                    check_field("first_angle_word", want.first_angle_word, m_first_angle_word);
                    check_field("last_angle_word", want.last_angle_word, m_last_angle_word);
                    check_field("sample_count", want.sample_count, m_sample_count);
                    check_field("sample_bytes", want.sample_bytes, m_sample_bytes);
                end
            end
        end
        mismatch_count <= bad;
        results_due    <= due_level;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module testbench;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int NO_ABORT    = -1;

    // How the closing checksum word of a generated frame is spoiled, if at all.
    typedef enum logic [1:0] {
        CHK_GOOD,
        CHK_FLIP,
        CHK_TOP_BIT
    } chk_mode_t;

    logic        aclk               = 1'b0;
    logic        aresetn            = 1'b0;
    logic        cfg_valid          = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data           = 8'h00;
    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte          = 8'h00;
    logic        s_link_fault       = 1'b0;
    logic        m_valid;
    logic        m_ready            = 1'b0;
    logic        m_kind;
    logic [2:0]  m_status;
    logic [7:0]  m_sample_index;
    logic [13:0] m_distance;
    logic        m_invalid;
    logic [15:0] m_quality;
    logic [9:0]  m_speed_rpm;
    logic [15:0] m_first_angle_word;
    logic [15:0] m_last_angle_word;
    logic [7:0]  m_sample_count;
    logic [2:0]  m_sample_bytes;

    int          mismatch_count;
    int          results_due;

    // quiet turns off idling on both sides; hold_arm starts the one long receiver hold.
    logic        quiet              = 1'b0;
    logic        hold_arm           = 1'b0;
    int          hold_left          = 300;
    int          items_sent         = 0;
    int unsigned cycle_count        = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    range_packet_deframer_checker dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .s_link_fault       (s_link_fault),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_sample_index     (m_sample_index),
        .m_distance         (m_distance),
        .m_invalid          (m_invalid),
        .m_quality          (m_quality),
        .m_speed_rpm        (m_speed_rpm),
        .m_first_angle_word (m_first_angle_word),
        .m_last_angle_word  (m_last_angle_word),
        .m_sample_count     (m_sample_count),
        .m_sample_bytes     (m_sample_bytes)
    );

    deframe_check u_deframe_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .s_link_fault       (s_link_fault),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_status           (m_status),
        .m_sample_index     (m_sample_index),
        .m_distance         (m_distance),
        .m_invalid          (m_invalid),
        .m_quality          (m_quality),
        .m_speed_rpm        (m_speed_rpm),
        .m_first_angle_word (m_first_angle_word),
        .m_last_angle_word  (m_last_angle_word),
        .m_sample_count     (m_sample_count),
        .m_sample_bytes     (m_sample_bytes),
        .mismatch_count     (mismatch_count),
        .results_due        (results_due)
    );

    // Receiver: drop ready at random, about 9 times in 100, except in quiet stretches.
    // Once armed, hold ready low until hold_left counts down to zero so the result
    // buffer fills and the block has to stall its byte input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_arm && hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    // Watchdog: end the run if the traffic ever hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Corner bytes show up often so that zero, all-ones and sign-like patterns
    // reach every field; the rest is uniform.
    function automatic logic [7:0] pick_byte();
        logic [7:0] data;
        data = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0:       data = 8'h00;
                1:       data = 8'hFF;
                2:       data = 8'h80;
                3:       data = 8'h7F;
                4:       data = 8'h3F;
                default: data = 8'h40;
            endcase
        end
        return data;
    endfunction

    function automatic logic [7:0] pick_size_code();
        case ($urandom_range(0, 2))
            0:       return rpdc_pkg::SIZE_CODE_2B;
            1:       return rpdc_pkg::SIZE_CODE_3B;
            default: return rpdc_pkg::SIZE_CODE_4B;
        endcase
    endfunction

    // Checksum of a frame body (size code onward, through the last angle word):
    // shift-add over little-endian byte pairs, an odd trailing byte left out,
    // then fold to 15 bits.
    function automatic logic [15:0] frame_checksum(input logic [7:0] body[$]);
        logic [31:0] acc;
        logic [14:0] fold;
        acc = rpdc_pkg::CHK_SEED;
        for (int i = 0; i + 1 < body.size(); i += 2)
            acc = (acc << 1) + {16'h0000, body[i+1], body[i]};
        fold = acc[14:0] + acc[29:15];
        return {1'b0, fold};
    endfunction

    // Offer one byte beat and hold it until the block takes it. Random idle
    // cycles go in front, so gaps land on every phase of a frame.
    task automatic send_beat(input logic [7:0] b, input logic fault);
        while (!quiet && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_rx_byte    <= b;
        s_link_fault <= fault;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Build and send one frame. A bad size code ends the frame after the count
    // byte. With fixed set every content byte is fill; otherwise content is
    // random and about one sample in ten gets a zero distance. abort_at
    // replaces that beat with a link fault and drops the rest of the frame.
    task automatic send_packet(input logic [7:0] code, input logic [7:0] count,
                               input chk_mode_t chk, input int abort_at,
                               input logic fixed, input logic [7:0] fill);
        logic [7:0]  body[$];
        logic [7:0]  frame[$];
        logic [7:0]  data;
        logic [15:0] chk_word;
        logic        zero_dist;
        logic        aborted;
        int          bps;
        bps      = (code == rpdc_pkg::SIZE_CODE_2B) ? 2 :
                   (code == rpdc_pkg::SIZE_CODE_3B) ? 3 :
                   (code == rpdc_pkg::SIZE_CODE_4B) ? 4 : 0;
        aborted  = 1'b0;
        chk_word = '0;
        body.push_back(code);
        body.push_back(count);
        if (bps != 0) begin
            // speed word and first angle word
            repeat (4) body.push_back(fixed ? fill : pick_byte());
            for (int s = 0; s < count; s++) begin
                zero_dist = !fixed && ($urandom_range(0, 9) == 0);
                for (int k = 0; k < bps; k++) begin
                    data = fixed ? fill : pick_byte();
                    if (zero_dist && k == 0) data = 8'h00;
                    if (zero_dist && k == 1) data = data & 8'hC0;
                    body.push_back(data);
                end
            end
            // last angle word
            repeat (2) body.push_back(fixed ? fill : pick_byte());
            chk_word = frame_checksum(body);
            if (chk == CHK_FLIP) chk_word = chk_word ^ 16'($urandom_range(1, 16'h7FFF));
            else if (chk == CHK_TOP_BIT) chk_word[15] = 1'b1;
        end
        frame.push_back(rpdc_pkg::HDR_FIRST);
        frame.push_back(rpdc_pkg::HDR_SECOND);
        foreach (body[i]) frame.push_back(body[i]);
        if (bps != 0) begin
            frame.push_back(chk_word[7:0]);
            frame.push_back(chk_word[15:8]);
        end
        for (int i = 0; i < frame.size() && !aborted; i++) begin
            if (i == abort_at) begin
                send_beat(pick_byte(), 1'b1);
                aborted = 1'b1;
            end else begin
                send_beat(frame[i], 1'b0);
            end
        end
    endtask

    // Mostly clean frames with random content, a few noise bytes in front of
    // each; the rest bad size codes, frames cut by a link fault and loose junk.
    task automatic random_traffic(input int stop_at, input int max_noise);
        int         pick;
        int         count;
        chk_mode_t  chk;
        logic [7:0] data;
        logic [7:0] code;
        while (items_sent < stop_at) begin
            repeat ($urandom_range(0, max_noise)) begin
                data = pick_byte();
                // keep noise from opening a header by accident
                if (data == rpdc_pkg::HDR_FIRST) data = ~data;
                send_beat(data, 1'b0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                count = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 6)
                                                     : $urandom_range(7, 24);
                case ($urandom_range(0, 19))
                    0, 1:    chk = CHK_FLIP;
                    2:       chk = CHK_TOP_BIT;
                    default: chk = CHK_GOOD;
                endcase
                send_packet(pick_size_code(), 8'(count), chk, NO_ABORT, 1'b0, 8'h00);
            end else if (pick < 80) begin
                do code = pick_byte();
                while (code == rpdc_pkg::SIZE_CODE_2B || code == rpdc_pkg::SIZE_CODE_3B
                       || code == rpdc_pkg::SIZE_CODE_4B);
                send_packet(code, 8'($urandom_range(0, 255)), CHK_GOOD, NO_ABORT, 1'b0, 8'h00);
            end else if (pick < 90) begin
                // full count range here: the fault cuts the frame short
                send_packet(pick_size_code(), 8'($urandom_range(0, 255)), CHK_GOOD,
                            $urandom_range(0, 30), 1'b0, 8'h00);
            end else begin
                repeat ($urandom_range(1, 6)) send_beat(pick_byte(), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Drop valid and wait for every predicted result, then let the pipeline
    // settle before touching the config register.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_hunt_limit(input logic [7:0] limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, at the reset hunt limit: a link fault while hunting, an
        // all-ones 3-byte frame (odd body, so one byte stays out of the
        // checksum), and an all-zero 2-byte frame whose only sample has zero
        // distance and whose checksum word has bit 15 set.
        send_beat(8'h3C, 1'b1);
        send_packet(rpdc_pkg::SIZE_CODE_3B, 8'd1, CHK_GOOD, NO_ABORT, 1'b1, 8'hFF);
        send_packet(rpdc_pkg::SIZE_CODE_2B, 8'd1, CHK_TOP_BIT, NO_ABORT, 1'b1, 8'h00);
        random_traffic(200, 3);

        // Widest hunt window. Hold the receiver off while a long frame streams
        // in so the block backs up, then pause the sender until it drains.
        wait_idle();
        write_hunt_limit(8'd255);
        quiet    <= 1'b1;
        hold_arm <= 1'b1;
        send_packet(rpdc_pkg::SIZE_CODE_3B, 8'd30, CHK_GOOD, NO_ABORT, 1'b0, 8'h00);
        wait_idle();
        random_traffic(items_sent + 80, 3);
        quiet <= 1'b0;
        random_traffic(420, 8);

        // Narrowest window: every hunted byte times out.
        wait_idle();
        write_hunt_limit(8'd1);
        repeat (20) send_beat(pick_byte(), $urandom_range(0, 9) == 0);

        // Short window: the header completes on the very byte that times out.
        wait_idle();
        write_hunt_limit(8'd6);
        send_beat(8'h11, 1'b0);
        send_beat(8'h22, 1'b0);
        send_beat(8'h33, 1'b0);
        send_beat(8'h44, 1'b0);
        send_beat(rpdc_pkg::HDR_FIRST, 1'b0);
        send_beat(rpdc_pkg::HDR_SECOND, 1'b0);
        random_traffic(560, 3);

        wait_idle();
        write_hunt_limit(rpdc_pkg::HUNT_LIMIT_RESET);
        random_traffic(630, 3);

        wait_idle();
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
